### rtl/core/tpv_pkg.sv
package tpv_pkg;

    localparam int NS_MAX_BYTES = 32;
    localparam int ID_MAX_LEN   = 64;
    localparam int NS_WORDS     = 4;
    localparam int KIND_REG_LEN = 12;
    localparam int KIND_TEL_LEN = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NS_LENGTH = 3'd0,
        REG_NS_LO     = 3'd1,
        REG_NS_MID_LO = 3'd2,
        REG_NS_MID_HI = 3'd3,
        REG_NS_HI     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_ID     = 2'd2,
        ST_KIND   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_REGISTRATION = 1'b0,
        KIND_TELEMETRY    = 1'b1
    } msg_kind_t;

    typedef struct packed {
        logic [1:0] slash_count;
        logic [5:0] prefix_position;
        logic       prefix_matches;
        logic [6:0] id_count;
        logic       id_chars_ok;
        logic [3:0] kind_position;
        logic [1:0] kind_flags;
    } topic_state_t;

    localparam topic_state_t TOPIC_RESET = '{
        slash_count:     2'd0,
        prefix_position: 6'd0,
        prefix_matches:  1'b1,
        id_count:        7'd0,
        id_chars_ok:     1'b1,
        kind_position:   4'd0,
        kind_flags:      2'b11
    };

    typedef struct packed {
        logic [6:0] id_length;
        logic [5:0] id_offset;
        msg_kind_t  message_kind;
        status_t    status;
    } result_t;

    function automatic logic id_char_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == 8'h2E || c == 8'h5F ||
               c == 8'h3A || c == 8'h2D;
    endfunction

    // "registration"; positions past the end give 0, callers check length
    function automatic logic [7:0] kind_reg_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h72;
            4'd1:    ch = 8'h65;
            4'd2:    ch = 8'h67;
            4'd3:    ch = 8'h69;
            4'd4:    ch = 8'h73;
            4'd5:    ch = 8'h74;
            4'd6:    ch = 8'h72;
            4'd7:    ch = 8'h61;
            4'd8:    ch = 8'h74;
            4'd9:    ch = 8'h69;
            4'd10:   ch = 8'h6F;
            4'd11:   ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "telemetry"
    function automatic logic [7:0] kind_tel_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h74;
            4'd1:    ch = 8'h65;
            4'd2:    ch = 8'h6C;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h6D;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h72;
            4'd8:    ch = 8'h79;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/tpv_cfg_regs.sv
module tpv_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [5:0]                      ns_pos,
    output logic [5:0]                      ns_length,
    output logic [7:0]                      ns_byte
);

    logic [5:0]                       ns_length_reg;
    logic [tpv_pkg::CFG_DATA_W-1:0]   ns_word_reg [tpv_pkg::NS_WORDS];
    logic [tpv_pkg::CFG_DATA_W-1:0]   sel_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_length_reg <= 6'd0;
            for (int i = 0; i < tpv_pkg::NS_WORDS; i++)
            begin
                ns_word_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpv_pkg::REG_NS_LENGTH: ns_length_reg  <= cfg_data[5:0];
                tpv_pkg::REG_NS_LO:     ns_word_reg[0] <= cfg_data;
                tpv_pkg::REG_NS_MID_LO: ns_word_reg[1] <= cfg_data;
                tpv_pkg::REG_NS_MID_HI: ns_word_reg[2] <= cfg_data;
                tpv_pkg::REG_NS_HI:     ns_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // bytes past the stored 32 read as zero
    always_comb
    begin
        sel_word = ns_word_reg[ns_pos[4:3]];
        ns_byte  = ns_pos[5] ? 8'h00 : sel_word[{ns_pos[2:0], 3'b000} +: 8];
    end

    assign ns_length = ns_length_reg;

endmodule

### rtl/core/tpv_step.sv
module tpv_step (
    input  tpv_pkg::topic_state_t  state,
    input  logic [7:0]             topic_char,
    input  logic                   is_last,
    input  logic [5:0]             ns_length,
    input  logic [7:0]             ns_byte,
    output tpv_pkg::topic_state_t  state_next,
    output tpv_pkg::result_t       result
);

    tpv_pkg::topic_state_t upd;

    always_comb
    begin
        upd = state;
        if (topic_char == 8'h2F)
        begin
            if (state.slash_count == 2'd0 && state.prefix_position != ns_length)
            begin
                upd.prefix_matches = 1'b0;
            end
            if (state.slash_count != 2'd3)
            begin
                upd.slash_count = state.slash_count + 2'd1;
            end
        end
        else
        begin
            unique case (state.slash_count)
                2'd0:
                begin
                    if (state.prefix_position >= ns_length || ns_byte != topic_char)
                    begin
                        upd.prefix_matches = 1'b0;
                    end
                    if (state.prefix_position != 6'd63)
                    begin
                        upd.prefix_position = state.prefix_position + 6'd1;
                    end
                end
                2'd1:
                begin
                    if (!tpv_pkg::id_char_ok(topic_char))
                    begin
                        upd.id_chars_ok = 1'b0;
                    end
                    if (state.id_count < 7'(tpv_pkg::ID_MAX_LEN + 1))
                    begin
                        upd.id_count = state.id_count + 7'd1;
                    end
                end
                2'd2:
                begin
                    if (state.kind_position >= 4'(tpv_pkg::KIND_REG_LEN) ||
                        tpv_pkg::kind_reg_char(state.kind_position) != topic_char)
                    begin
                        upd.kind_flags[0] = 1'b0;
                    end
                    if (state.kind_position >= 4'(tpv_pkg::KIND_TEL_LEN) ||
                        tpv_pkg::kind_tel_char(state.kind_position) != topic_char)
                    begin
                        upd.kind_flags[1] = 1'b0;
                    end
                    if (state.kind_position != 4'd15)
                    begin
                        upd.kind_position = state.kind_position + 4'd1;
                    end
                end
                default: ;
            endcase
        end

        result.status       = tpv_pkg::ST_OK;
        result.message_kind = tpv_pkg::KIND_REGISTRATION;
        result.id_offset    = 6'd0;
        result.id_length    = 7'd0;
        if (upd.slash_count != 2'd2 || !upd.prefix_matches ||
            {1'b0, ns_length} > 7'(tpv_pkg::NS_MAX_BYTES))
        begin
            result.status = tpv_pkg::ST_FORMAT;
        end
        else
        begin
            result.id_offset = upd.prefix_position + 6'd1;
            result.id_length = upd.id_count;
            priority if (upd.id_count == 7'd0 ||
                         upd.id_count > 7'(tpv_pkg::ID_MAX_LEN) || !upd.id_chars_ok)
            begin
                result.status = tpv_pkg::ST_ID;
            end
            else if (upd.kind_flags[0] &&
                     upd.kind_position == 4'(tpv_pkg::KIND_REG_LEN))
            begin
                result.status = tpv_pkg::ST_OK;
            end
            else if (upd.kind_flags[1] &&
                     upd.kind_position == 4'(tpv_pkg::KIND_TEL_LEN))
            begin
                result.status       = tpv_pkg::ST_OK;
                result.message_kind = tpv_pkg::KIND_TELEMETRY;
            end
            else
            begin
                result.status = tpv_pkg::ST_KIND;
            end
        end

        state_next = is_last ? tpv_pkg::TOPIC_RESET : upd;
    end

endmodule

### rtl/core/topic_path_validator.sv
// channel | dir | beat fields (low bit first)
// s_*     | in  | tdata[7:0] topic_char, tlast is_last
// m_*     | out | tdata[1:0] status, [2] message_kind, [8:3] id_offset, [15:9] id_length
// cfg_*   | in  | cfg_index register number, cfg_data value (namespace_length in [5:0])
// One byte per cycle while s_tready is high. A byte is held in the input register,
// then the step logic updates the topic state and, on a last beat, loads the result
// register and sets the output valid register behind m_tvalid along with it.
// Reset clears state and config at once; no clearing pass.
// A result held by m_tready low stalls both stages and drops s_tready.
module topic_path_validator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] topic_char
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // status, message_kind, id_offset, id_length
);

    logic                   advance;
    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;
    tpv_pkg::topic_state_t  state_reg;
    tpv_pkg::topic_state_t  state_next;
    tpv_pkg::result_t       result_next;
    tpv_pkg::result_t       result_reg;
    logic                   out_valid_reg;
    logic [5:0]             ns_length;
    logic [7:0]             ns_byte;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    tpv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ns_pos    (state_reg.prefix_position),
        .ns_length (ns_length),
        .ns_byte   (ns_byte)
    );

    tpv_step u_step (
        .state      (state_reg),
        .topic_char (in_char_reg),
        .is_last    (in_last_reg),
        .ns_length  (ns_length),
        .ns_byte    (ns_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= tpv_pkg::TOPIC_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= s_tvalid;
            out_valid_reg <= in_valid_reg && in_last_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
            if (in_valid_reg && in_last_reg)
            begin
                result_reg <= result_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.id_length, result_reg.id_offset,
                       result_reg.message_kind, result_reg.status};

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && in_last_reg |=> state_reg == tpv_pkg::TOPIC_RESET)
        else $error("topic state not cleared after last beat");

    a_ok_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == tpv_pkg::ST_OK |->
            result_reg.id_length != 7'd0 &&
            result_reg.id_length <= 7'(tpv_pkg::ID_MAX_LEN))
        else $error("accepted topic with bad id length");

    a_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == tpv_pkg::ST_FORMAT |->
            result_reg.id_offset == 6'd0 && result_reg.id_length == 7'd0)
        else $error("format error with id fields set");

    a_kind_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.message_kind == tpv_pkg::KIND_TELEMETRY |->
            result_reg.status == tpv_pkg::ST_OK)
        else $error("telemetry kind on failed topic");

endmodule

### test/topic_path_validator_tb.sv
module topic_path_validator_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [7:0] SLASH = 8'h2F;

    typedef struct packed {
        logic             typed;
        tpv_pkg::result_t res;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    tpv_pkg::cfg_reg_t              cfg_index = tpv_pkg::REG_NS_LENGTH;
    logic [tpv_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = 8'h00;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;

    topic_path_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    string reg_word = "registration";
    string tel_word = "telemetry";
    string id_chars = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ._:-";

    tpv_pkg::cfg_reg_t word_regs [4] = '{tpv_pkg::REG_NS_LO, tpv_pkg::REG_NS_MID_LO,
                                         tpv_pkg::REG_NS_MID_HI, tpv_pkg::REG_NS_HI};

    string dir_topics [19] = '{
        "/a/registration",
        "/dev-01/telemetry",
        "a/x/telemetry",
        "/x",
        "/x/y/z",
        "//registration",
        "/x/",
        "/a b/telemetry",
        "/x/registratio",
        "/x/telemetryx",
        "/\377\200/telemetry",
        "/A.Z_a:z-09/registration",
        "/",
        "///",
        "/id/telemetry/xx",
        "/q/TELEMETRY",
        "registration",
        "/0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-/telemetry",
        "/0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-_/telemetry"
    };

    dir_row_t dir_expect [19] = '{
        '{1'b1, '{7'd1,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_OK}},
        '{1'b1, '{7'd6,  6'd1, tpv_pkg::KIND_TELEMETRY,    tpv_pkg::ST_OK}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd0,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_ID}},
        '{1'b1, '{7'd1,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_KIND}},
        '{1'b1, '{7'd3,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_ID}},
        '{1'b1, '{7'd1,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_KIND}},
        '{1'b1, '{7'd1,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_KIND}},
        '{1'b1, '{7'd2,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_ID}},
        '{1'b0, '0},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd1,  6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_KIND}},
        '{1'b1, '{7'd0,  6'd0, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_FORMAT}},
        '{1'b1, '{7'd64, 6'd1, tpv_pkg::KIND_TELEMETRY,    tpv_pkg::ST_OK}},
        '{1'b1, '{7'd65, 6'd1, tpv_pkg::KIND_REGISTRATION, tpv_pkg::ST_ID}}
    };

    // predicted block state and register copy
    logic [1:0]  p_slashes;
    logic [5:0]  p_prefix_pos;
    logic        p_prefix_ok;
    logic [6:0]  p_id_count;
    logic        p_id_ok;
    logic [3:0]  p_kind_pos;
    logic [1:0]  p_kind_flags;
    logic [5:0]  ns_len;
    logic [63:0] ns_words [4];

    tpv_pkg::result_t pending_results [$];
    logic [7:0]       topic_buf [$];

    int fail_count = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int bytes_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rcv_cycle = 0;
    int rcv_mode = 0;

    function automatic void clear_topic_state();
        p_slashes    = 2'd0;
        p_prefix_pos = 6'd0;
        p_prefix_ok  = 1'b1;
        p_id_count   = 7'd0;
        p_id_ok      = 1'b1;
        p_kind_pos   = 4'd0;
        p_kind_flags = 2'b11;
    endfunction

    function automatic logic [7:0] ns_char(input logic [5:0] pos);
        if (pos >= tpv_pkg::NS_MAX_BYTES)
            return 8'h00;
        return ns_words[pos[4:3]][pos[2:0] * 8 +: 8];
    endfunction

    function automatic logic id_char_allowed(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "." || c == "_" || c == ":" || c == "-";
    endfunction

    function automatic logic [7:0] any_but_slash();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == SLASH);
        return c;
    endfunction

    function automatic logic [7:0] bad_id_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == SLASH || id_char_allowed(c));
        return c;
    endfunction

    // advances the topic state by one byte; on the last byte yields the verdict
    function automatic logic validate_byte(input logic [7:0] c, input logic last,
                                           output tpv_pkg::result_t res);
        res = '0;
        if (c == SLASH)
        begin
            if (p_slashes == 2'd0 && p_prefix_pos != ns_len)
                p_prefix_ok = 1'b0;
            if (p_slashes != 2'd3)
                p_slashes = p_slashes + 2'd1;
        end
        else if (p_slashes == 2'd0)
        begin
            if (p_prefix_pos >= ns_len || ns_char(p_prefix_pos) != c)
                p_prefix_ok = 1'b0;
            if (p_prefix_pos != 6'd63)
                p_prefix_pos = p_prefix_pos + 6'd1;
        end
        else if (p_slashes == 2'd1)
        begin
            if (!id_char_allowed(c))
                p_id_ok = 1'b0;
            if (p_id_count <= tpv_pkg::ID_MAX_LEN)
                p_id_count = p_id_count + 7'd1;
        end
        else if (p_slashes == 2'd2)
        begin
            if (p_kind_pos >= tpv_pkg::KIND_REG_LEN || reg_word[p_kind_pos] != c)
                p_kind_flags[0] = 1'b0;
            if (p_kind_pos >= tpv_pkg::KIND_TEL_LEN || tel_word[p_kind_pos] != c)
                p_kind_flags[1] = 1'b0;
            if (p_kind_pos != 4'd15)
                p_kind_pos = p_kind_pos + 4'd1;
        end
        if (!last)
            return 1'b0;
        if (p_slashes != 2'd2 || !p_prefix_ok || ns_len > tpv_pkg::NS_MAX_BYTES)
            res.status = tpv_pkg::ST_FORMAT;
        else
        begin
            res.id_offset = p_prefix_pos + 6'd1;
            res.id_length = p_id_count;
            if (p_id_count == 0 || p_id_count > tpv_pkg::ID_MAX_LEN || !p_id_ok)
                res.status = tpv_pkg::ST_ID;
            else if (p_kind_flags[0] && p_kind_pos == tpv_pkg::KIND_REG_LEN)
                res.status = tpv_pkg::ST_OK;
            else if (p_kind_flags[1] && p_kind_pos == tpv_pkg::KIND_TEL_LEN)
            begin
                res.status       = tpv_pkg::ST_OK;
                res.message_kind = tpv_pkg::KIND_TELEMETRY;
            end
            else
                res.status = tpv_pkg::ST_KIND;
        end
        clear_topic_state();
        return 1'b1;
    endfunction

    task automatic write_reg(input tpv_pkg::cfg_reg_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            tpv_pkg::REG_NS_LENGTH: ns_len      = value[5:0];
            tpv_pkg::REG_NS_LO:     ns_words[0] = value;
            tpv_pkg::REG_NS_MID_LO: ns_words[1] = value;
            tpv_pkg::REG_NS_MID_HI: ns_words[2] = value;
            tpv_pkg::REG_NS_HI:     ns_words[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_namespace(input logic [5:0] len);
        logic [63:0] w;
        int k;
        int b;
        w = {$urandom, $urandom};
        w[5:0] = len;
        write_reg(tpv_pkg::REG_NS_LENGTH, w);
        for (k = 0; k < 4; k++)
        begin
            w = {$urandom, $urandom};
            for (b = 0; b < 8; b++)
                if (k * 8 + b < len && w[b * 8 +: 8] == SLASH)
                    w[b * 8 +: 8] = ".";
            write_reg(word_regs[k], w);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last,
                             input logic typed, input tpv_pkg::result_t typed_res);
        int gap;
        tpv_pkg::result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (validate_byte(c, last, res))
            pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic send_topic(input logic typed, input tpv_pkg::result_t typed_res);
        int i;
        for (i = 0; i < topic_buf.size(); i++)
            send_byte(topic_buf[i], i == topic_buf.size() - 1, typed, typed_res);
    endtask

    task automatic wait_results_in();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly well-formed namespace/id/kind with random content, the rest noise
    task automatic build_topic();
        int n;
        int i;
        int roll;
        string word;
        topic_buf.delete();
        if ($urandom_range(0, 99) < 25)
        begin
            n = $urandom_range(1, 30);
            for (i = 0; i < n; i++)
                topic_buf.push_back(($urandom_range(0, 4) == 0) ? SLASH
                                                                : 8'($urandom_range(0, 255)));
            return;
        end
        for (i = 0; i < ns_len; i++)
            topic_buf.push_back(i < tpv_pkg::NS_MAX_BYTES ? ns_char(6'(i)) : any_but_slash());
        if ($urandom_range(0, 9) == 0)
        begin
            if (ns_len != 0 && $urandom_range(0, 1) == 1)
                topic_buf[$urandom_range(0, ns_len - 1)] = any_but_slash();
            else
                topic_buf.push_back(any_but_slash());
        end
        topic_buf.push_back(SLASH);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            n = 0;
        else if (roll < 9)
            n = tpv_pkg::ID_MAX_LEN;
        else if (roll < 14)
            n = $urandom_range(tpv_pkg::ID_MAX_LEN + 1, tpv_pkg::ID_MAX_LEN + 6);
        else if (roll < 18)
            n = $urandom_range(13, tpv_pkg::ID_MAX_LEN - 1);
        else
            n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
            topic_buf.push_back(id_chars[$urandom_range(0, id_chars.len() - 1)]);
        if (n != 0 && $urandom_range(0, 9) == 0)
            topic_buf[topic_buf.size() - 1 - $urandom_range(0, n - 1)] = bad_id_char();
        topic_buf.push_back(SLASH);
        roll = $urandom_range(0, 99);
        word = (roll < 45) ? reg_word : tel_word;
        for (i = 0; i < word.len(); i++)
            topic_buf.push_back(word[i]);
        if (roll >= 90)
        begin
            case ($urandom_range(0, 3))
                0: void'(topic_buf.pop_back());
                1: topic_buf.push_back(any_but_slash());
                2: topic_buf[topic_buf.size() - 1 - $urandom_range(0, word.len() - 1)] =
                       any_but_slash();
                default: repeat (word.len()) void'(topic_buf.pop_back());
            endcase
        end
        if ($urandom_range(0, 14) == 0)
        begin
            topic_buf.push_back(SLASH);
            topic_buf.push_back(any_but_slash());
        end
    endtask

    // receiver: changing ready patterns, plus a long hold-off on request
    always @(posedge clk)
    begin
        rcv_cycle <= rcv_cycle + 1;
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rcv_cycle % 64 == 0)
                rcv_mode <= $urandom_range(0, 3);
            case (rcv_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rcv_cycle % 8) < 4);
            endcase
        end
    end

    // result beat check
    always @(posedge clk)
    begin
        tpv_pkg::result_t seen;
        tpv_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = tpv_pkg::result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: m_tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (seen.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, seen.status);
                    fail_count++;
                end
                if (seen.message_kind !== want.message_kind)
                begin
                    $error("message_kind expected %0d actual %0d",
                           want.message_kind, seen.message_kind);
                    fail_count++;
                end
                if (seen.id_offset !== want.id_offset)
                begin
                    $error("id_offset expected %0d actual %0d", want.id_offset, seen.id_offset);
                    fail_count++;
                end
                if (seen.id_length !== want.id_length)
                begin
                    $error("id_length expected %0d actual %0d", want.id_length, seen.id_length);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int i;
        int j;
        int phase;
        int target;
        int phase_end;
        logic [5:0] len;

        ns_len = 6'd0;
        for (i = 0; i < 4; i++)
            ns_words[i] = 64'd0;
        clear_topic_state();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 19; i++)
        begin
            topic_buf.delete();
            for (j = 0; j < dir_topics[i].len(); j++)
                topic_buf.push_back(dir_topics[i][j]);
            send_topic(dir_expect[i].typed, dir_expect[i].res);
        end

        target = bytes_sent + RANDOM_BYTES;
        phase = 0;
        while (bytes_sent < target)
        begin
            wait_results_in();
            case (phase % 7)
                0:       len = 6'(tpv_pkg::NS_MAX_BYTES);
                1:       len = 6'($urandom_range(1, 8));
                2:       len = 6'd0;
                3:       len = 6'd63;
                4:       len = 6'($urandom_range(9, tpv_pkg::NS_MAX_BYTES - 1));
                5:       len = 6'(tpv_pkg::NS_MAX_BYTES + 1);
                default: len = 6'($urandom_range(1, 4));
            endcase
            set_namespace(len);
            // block fills up while results are held back
            if (phase == 2)
                hold_asks <= hold_asks + 1;
            phase_end = bytes_sent + ((len > tpv_pkg::NS_MAX_BYTES) ? 80 : 200);
            while (bytes_sent < phase_end && bytes_sent < target)
            begin
                build_topic();
                send_topic(1'b0, '0);
                if ($urandom_range(0, 19) == 0)
                    wait_results_in();
            end
            phase++;
        end

        wait_results_in();
        $display("%0d topic bytes over %0d namespace settings, %0d results checked",
                 bytes_sent, phase, results_checked);
        $display("verdicts: ok %0d, format %0d, id %0d, kind %0d",
                 status_seen[tpv_pkg::ST_OK], status_seen[tpv_pkg::ST_FORMAT],
                 status_seen[tpv_pkg::ST_ID], status_seen[tpv_pkg::ST_KIND]);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
